// ===== sv/qrs_pkg.sv =====
// qrs_pkg: shared constants and result status codes for the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_TWO_ROOTS = 2'd0,
        ST_DOUBLE    = 2'd1,
        ST_A_ZERO    = 2'd2,
        ST_NEG_DISC  = 2'd3
    } status_t;

endpackage

// ===== sv/qrs_disc.sv =====
// qrs_disc: input register, coefficient products and discriminant with status
`timescale 1ns / 1ps
module qrs_disc #(
    parameter int CW = qrs_pkg::COEF_WIDTH,
    parameter int DW = 2 * qrs_pkg::COEF_WIDTH + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] coef_a,
    input  logic signed [CW-1:0] coef_b,
    input  logic signed [CW-1:0] coef_c,
    output logic                 out_valid,
    output logic [DW-1:0]        out_dmag,
    output qrs_pkg::status_t     out_status,
    output logic signed [CW:0]   out_nb,
    output logic                 out_den_neg,
    output logic [CW:0]          out_den_mag
);

    // stage 0: input register
    logic                 v0_reg;
    logic signed [CW-1:0] a0_reg, b0_reg, c0_reg;
    // stage 1: products
    logic                 v1_reg;
    logic [2*CW-1:0]      bb1_reg, ac1_reg;
    logic [CW-1:0]        amag1_reg;
    logic                 aneg1_reg, azero1_reg, mixed1_reg;
    logic signed [CW-1:0] b1_reg;
    // stage 2 next values
    logic [CW-1:0]        amag, bmag, cmag;
    logic [2*CW-1:0]      bb_next, ac_next;
    logic [DW-1:0]        b2, p4, dmag_next;
    logic                 dneg;
    qrs_pkg::status_t     status_next;

    always_comb begin
        amag    = a0_reg[CW-1] ? (~a0_reg + 1'b1) : a0_reg;
        bmag    = b0_reg[CW-1] ? (~b0_reg + 1'b1) : b0_reg;
        cmag    = c0_reg[CW-1] ? (~c0_reg + 1'b1) : c0_reg;
        bb_next = (2*CW)'(bmag) * (2*CW)'(bmag);
        ac_next = (2*CW)'(amag) * (2*CW)'(cmag);
    end

    // discriminant held in DW bits, wrapping like a 64-bit datapath at the widest setting
    always_comb begin
        b2   = DW'(bb1_reg);
        p4   = DW'({ac1_reg, 2'b00});
        dneg = 1'b0;
        if (mixed1_reg) begin
            dmag_next = b2 + p4;
        end else if (b2 >= p4) begin
            dmag_next = b2 - p4;
        end else begin
            dmag_next = p4 - b2;
            dneg      = 1'b1;
        end
        if (azero1_reg) begin
            status_next = qrs_pkg::ST_A_ZERO;
        end else if (dneg) begin
            status_next = qrs_pkg::ST_NEG_DISC;
        end else if (dmag_next == '0) begin
            status_next = qrs_pkg::ST_DOUBLE;
        end else begin
            status_next = qrs_pkg::ST_TWO_ROOTS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else if (en) begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg      <= coef_a;
            b0_reg      <= coef_b;
            c0_reg      <= coef_c;
            bb1_reg     <= bb_next;
            ac1_reg     <= ac_next;
            amag1_reg   <= amag;
            aneg1_reg   <= a0_reg[CW-1];
            azero1_reg  <= (a0_reg == '0);
            mixed1_reg  <= (a0_reg[CW-1] != c0_reg[CW-1]) && (c0_reg != '0);
            b1_reg      <= b0_reg;
            out_dmag    <= dmag_next;
            out_status  <= status_next;
            out_nb      <= -$signed({b1_reg[CW-1], b1_reg});
            out_den_neg <= aneg1_reg;
            out_den_mag <= {amag1_reg, 1'b0};
        end
    end

endmodule

// ===== sv/qrs_sqrt.sv =====
// qrs_sqrt: floor square root, one result bit per pipeline stage
`timescale 1ns / 1ps
module qrs_sqrt #(
    parameter int DW  = 34,
    parameter int SBW = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [DW-1:0]   in_x,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [DW/2-1:0] out_root,
    output logic [SBW-1:0]  out_sb
);

    localparam int SW = DW / 2;

    logic            v_reg    [SW];
    logic [DW-1:0]   x_reg    [SW];
    logic [SW+1:0]   rem_reg  [SW];
    logic [SW-1:0]   root_reg [SW];
    logic [SBW-1:0]  sb_reg   [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic            v_in;
        logic [DW-1:0]   x_in;
        logic [SW+1:0]   rem_in, r2, trial;
        logic [SW-1:0]   root_in;
        logic [SBW-1:0]  sb_in;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
        end

        // bring down the next two bits and try root*4+1
        always_comb begin
            r2    = {rem_in[SW-1:0], x_in[DW-1:DW-2]};
            trial = {root_in, 2'b01};
            ge    = (r2 >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= {x_in[DW-3:0], 2'b00};
                rem_reg[k]  <= ge ? (r2 - trial) : r2;
                root_reg[k] <= {root_in[SW-2:0], ge};
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[SW-1];
    assign out_root  = root_reg[SW-1];
    assign out_sb    = sb_reg[SW-1];

endmodule

// ===== sv/qrs_div.sv =====
// qrs_div: unsigned restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps
module qrs_div #(
    parameter int NW   = 18,
    parameter int FW   = 16,
    parameter int DENW = 17,
    parameter int SBW  = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NW-1:0]      in_num,
    input  logic [DENW-1:0]    in_den,
    input  logic [SBW-1:0]     in_sb,
    output logic               out_valid,
    output logic [NW+FW-1:0]   out_quot,
    output logic [SBW-1:0]     out_sb
);

    localparam int QW = NW + FW;

    logic            v_reg   [QW];
    logic [QW-1:0]   dq_reg  [QW];
    logic [DENW-1:0] rem_reg [QW];
    logic [DENW-1:0] den_reg [QW];
    logic [SBW-1:0]  sb_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            v_in;
        logic [QW-1:0]   dq_in;
        logic [DENW-1:0] rem_in, den_in;
        logic [SBW-1:0]  sb_in;
        logic [DENW:0]   r2;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign dq_in  = {in_num, {FW{1'b0}}};
            assign rem_in = '0;
            assign den_in = in_den;
            assign sb_in  = in_sb;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        // dividend bits shift out the top as quotient bits shift in below
        always_comb begin
            r2 = {rem_in, dq_in[QW-1]};
            ge = (r2 >= {1'b0, den_in});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dq_reg[k]  <= {dq_in[QW-2:0], ge};
                rem_reg[k] <= ge ? DENW'(r2 - {1'b0, den_in}) : DENW'(r2);
                den_reg[k] <= den_in;
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quot  = dq_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule

// ===== sv/quadratic_root_solver_top.sv =====
// quadratic_root_solver_top: pipelined real-root quadratic solver with output skid buffer
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | s_valid s_ready s_coef_a s_coef_b s_coef_c | in
//  result  | m_valid m_ready m_root_status m_root_plus  | out
//          | m_root_minus m_saturated                   |
//
// one transfer per cycle in and out while the skid entry is empty; s_ready drops while it is full.
// the square root and divider pipelines each produce one result bit per stage.
// reset clears all valid bits; data registers are not reset and no clearing pass is needed.
// a stalled result goes to a one-entry skid register; the pipeline freezes only
// once that skid entry is full, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int ROOT_WIDTH = qrs_pkg::ROOT_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COEF_WIDTH-1:0] s_coef_a,
    input  logic signed [COEF_WIDTH-1:0] s_coef_b,
    input  logic signed [COEF_WIDTH-1:0] s_coef_c,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_root_status,
    output logic signed [ROOT_WIDTH-1:0] m_root_plus,
    output logic signed [ROOT_WIDTH-1:0] m_root_minus,
    output logic                         m_saturated
);

    localparam int CW   = COEF_WIDTH;
    localparam int DW   = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
    localparam int SW   = DW / 2;
    localparam int NW   = SW + 1;
    localparam int FW   = ROOT_WIDTH / 2;
    localparam int DENW = CW + 1;
    localparam int QW   = NW + FW;
    localparam int CMPW = (QW > ROOT_WIDTH) ? QW : ROOT_WIDTH;
    localparam int SBW  = 2 + (CW + 1) + 1 + DENW;

    logic en;
    logic skid_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    // discriminant front end
    logic             d_valid;
    logic [DW-1:0]    d_dmag;
    qrs_pkg::status_t d_status;
    logic signed [CW:0] d_nb;
    logic             d_den_neg;
    logic [DENW-1:0]  d_den_mag;

    qrs_disc #(.CW(CW), .DW(DW)) u_disc (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready),
        .coef_a(s_coef_a), .coef_b(s_coef_b), .coef_c(s_coef_c),
        .out_valid(d_valid), .out_dmag(d_dmag), .out_status(d_status),
        .out_nb(d_nb), .out_den_neg(d_den_neg), .out_den_mag(d_den_mag)
    );

    // square root
    logic           q_valid;
    logic [SW-1:0]  q_root;
    logic [SBW-1:0] q_sb;

    qrs_sqrt #(.DW(DW), .SBW(SBW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid), .in_x(d_dmag),
        .in_sb({d_status, d_nb, d_den_neg, d_den_mag}),
        .out_valid(q_valid), .out_root(q_root), .out_sb(q_sb)
    );

    // numerator stage: -b plus and minus the root, as sign and magnitude
    qrs_pkg::status_t   q_status;
    logic signed [CW:0] q_nb;
    logic               q_den_neg;
    logic [DENW-1:0]    q_den_mag;
    logic signed [NW:0] np, nm;

    assign {q_status, q_nb, q_den_neg, q_den_mag} = q_sb;

    always_comb begin
        np = (NW+1)'(q_nb) + $signed({2'b00, q_root});
        nm = (NW+1)'(q_nb) - $signed({2'b00, q_root});
    end

    logic             n_v_reg;
    logic [NW-1:0]    np_mag_reg, nm_mag_reg;
    logic             np_neg_reg, nm_neg_reg;
    logic [DENW-1:0]  den_mag_reg;
    qrs_pkg::status_t n_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_v_reg <= 1'b0;
        end else if (en) begin
            n_v_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            np_mag_reg   <= np[NW] ? NW'(-np) : NW'(np);
            nm_mag_reg   <= nm[NW] ? NW'(-nm) : NW'(nm);
            np_neg_reg   <= np[NW] ^ q_den_neg;
            nm_neg_reg   <= nm[NW] ^ q_den_neg;
            den_mag_reg  <= q_den_mag;
            n_status_reg <= q_status;
        end
    end

    // two dividers in lockstep
    logic             vp_valid, vm_valid;
    logic [QW-1:0]    quot_p, quot_m;
    logic [2:0]       sbp;
    logic             sbm;
    qrs_pkg::status_t p_status;
    logic             p_neg;

    qrs_div #(.NW(NW), .FW(FW), .DENW(DENW), .SBW(3)) u_div_plus (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(n_v_reg), .in_num(np_mag_reg), .in_den(den_mag_reg),
        .in_sb({n_status_reg, np_neg_reg}),
        .out_valid(vp_valid), .out_quot(quot_p), .out_sb(sbp)
    );

    qrs_div #(.NW(NW), .FW(FW), .DENW(DENW), .SBW(1)) u_div_minus (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(n_v_reg), .in_num(nm_mag_reg), .in_den(den_mag_reg),
        .in_sb(nm_neg_reg),
        .out_valid(vm_valid), .out_quot(quot_m), .out_sb(sbm)
    );

    assign {p_status, p_neg} = sbp;

    // clip to range and apply sign
    localparam logic [CMPW-1:0] LIM_POS = CMPW'((64'd1 << (ROOT_WIDTH - 1)) - 64'd1);
    localparam logic [CMPW-1:0] LIM_NEG = CMPW'(64'd1 << (ROOT_WIDTH - 1));

    logic [CMPW-1:0]       lim_p, lim_m, qp_ext, qm_ext, mag_p, mag_m;
    logic                  sat_p, sat_m, has_roots;
    logic [ROOT_WIDTH-1:0] root_p, root_m;

    always_comb begin
        lim_p  = p_neg ? LIM_NEG : LIM_POS;
        lim_m  = sbm ? LIM_NEG : LIM_POS;
        qp_ext = CMPW'(quot_p);
        qm_ext = CMPW'(quot_m);
        sat_p  = qp_ext > lim_p;
        sat_m  = qm_ext > lim_m;
        mag_p  = sat_p ? lim_p : qp_ext;
        mag_m  = sat_m ? lim_m : qm_ext;
        has_roots = (p_status == qrs_pkg::ST_TWO_ROOTS) || (p_status == qrs_pkg::ST_DOUBLE);
        root_p = has_roots ? (p_neg ? ROOT_WIDTH'(-mag_p) : ROOT_WIDTH'(mag_p)) : '0;
        root_m = has_roots ? (sbm ? ROOT_WIDTH'(-mag_m) : ROOT_WIDTH'(mag_m)) : '0;
    end

    logic f_v_reg;
    logic [1:0] f_status_reg;
    logic [ROOT_WIDTH-1:0] f_plus_reg, f_minus_reg;
    logic f_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (en) begin
            f_v_reg <= vp_valid && vm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_status_reg <= p_status;
            f_plus_reg   <= root_p;
            f_minus_reg  <= root_m;
            f_sat_reg    <= has_roots && (sat_p || sat_m);
        end
    end

    // output register plus one skid entry
    logic                  new_item;
    logic                  out_v_reg;
    logic [1:0]            skid_status_reg;
    logic [ROOT_WIDTH-1:0] skid_plus_reg, skid_minus_reg;
    logic                  skid_sat_reg;

    assign new_item = en && f_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_ready || !out_v_reg) begin
            out_v_reg  <= skid_v_reg || new_item;
            skid_v_reg <= 1'b0;
        end else if (new_item) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_v_reg) begin
            if (skid_v_reg) begin
                m_root_status <= skid_status_reg;
                m_root_plus   <= skid_plus_reg;
                m_root_minus  <= skid_minus_reg;
                m_saturated   <= skid_sat_reg;
            end else begin
                m_root_status <= f_status_reg;
                m_root_plus   <= f_plus_reg;
                m_root_minus  <= f_minus_reg;
                m_saturated   <= f_sat_reg;
            end
        end else if (new_item) begin
            skid_status_reg <= f_status_reg;
            skid_plus_reg   <= f_plus_reg;
            skid_minus_reg  <= f_minus_reg;
            skid_sat_reg    <= f_sat_reg;
        end
    end

    assign m_valid = out_v_reg;

endmodule

// ===== sv/qrs_checker.sv =====
// qrs_checker: port-level assertions for the quadratic root solver, bound to the top level
`timescale 1ns / 1ps
module qrs_checker #(
    parameter int ROOT_WIDTH = qrs_pkg::ROOT_WIDTH
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_root_status,
    input logic [ROOT_WIDTH-1:0] m_root_plus,
    input logic [ROOT_WIDTH-1:0] m_root_minus,
    input logic                  m_saturated
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root_plus) && $stable(m_root_minus))
        else $error("result changed while stalled");

    // no roots means zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_status == qrs_pkg::ST_A_ZERO ||
                    m_root_status == qrs_pkg::ST_NEG_DISC)
        |-> m_root_plus == '0 && m_root_minus == '0 && !m_saturated)
        else $error("nonzero roots without real roots");

    // double root gives equal fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_status == qrs_pkg::ST_DOUBLE |-> m_root_plus == m_root_minus)
        else $error("double root fields differ");

    // nothing comes out right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quadratic_root_solver_top qrs_checker #(.ROOT_WIDTH(ROOT_WIDTH)) u_qrs_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_root_status(m_root_status), .m_root_plus(m_root_plus),
    .m_root_minus(m_root_minus), .m_saturated(m_saturated)
);

// ===== bench/quadratic_root_solver_top_tb.sv =====
// quadratic_root_solver_top_tb: directed table plus random coefficient sets, checked against a root predictor
`timescale 1ns / 1ps
module quadratic_root_solver_top_tb;

    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int RW = qrs_pkg::ROOT_WIDTH;
    localparam int RFRAC = RW / 2;
    localparam int N_RANDOM = 700;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [RW-1:0] plus;
        logic signed [RW-1:0] minus;
        logic                 sat;
    } roots_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;
        roots_t               want;
    } coef_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_coef_a;
    logic signed [CW-1:0] s_coef_b;
    logic signed [CW-1:0] s_coef_c;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_root_status;
    logic signed [RW-1:0] m_root_plus;
    logic signed [RW-1:0] m_root_minus;
    logic                 m_saturated;

    roots_t    pending_roots[$];
    coef_row_t table_rows[$];
    int        errors;
    int        idle_count;
    bit        calm;

    quadratic_root_solver_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // truncating signed divide into the root format, clipped at the bounds
    function automatic logic [RW-1:0] divide_root(longint num, longint den, inout bit sat);
        bit          neg;
        logic [63:0] n, d, ip, rem, mag, lim, half;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        ip = n / d;
        rem = n % d;
        half = 64'd1 << (RW - 1);
        lim = neg ? half : half - 1;
        if (ip > (half >> RFRAC)) begin
            mag = lim;
            sat = 1'b1;
        end else begin
            mag = ip;
            for (int i = 0; i < RFRAC; i++) begin
                rem = rem << 1;
                mag = mag << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    mag[0] = 1'b1;
                end
            end
            if (mag > lim) begin
                mag = lim;
                sat = 1'b1;
            end
        end
        if (neg) mag = -mag;
        return mag[RW-1:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [CW-1:0] ca, logic signed [CW-1:0] cb,
                                           logic signed [CW-1:0] cc);
        roots_t      r;
        longint      a, b, c, disc, s;
        logic [63:0] x, bitv, acc;
        bit          sat;
        a = ca;
        b = cb;
        c = cc;
        sat = 1'b0;
        r = '0;
        if (a == 0) begin
            r.status = qrs_pkg::ST_A_ZERO;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc < 0) begin
            r.status = qrs_pkg::ST_NEG_DISC;
            return r;
        end
        // floor square root, bit by bit
        x = disc;
        acc = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= acc + bitv) begin
                x = x - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        s = acc;
        r.status = (disc == 0) ? qrs_pkg::ST_DOUBLE : qrs_pkg::ST_TWO_ROOTS;
        r.plus = divide_root(-b + s, 2 * a, sat);
        r.minus = divide_root(-b - s, 2 * a, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic add_row(int a, int b, int c, bit typed = 0, roots_t want = '0);
        coef_row_t row;
        row.a = CW'(a);
        row.b = CW'(b);
        row.c = CW'(c);
        row.typed = typed;
        row.want = want;
        table_rows = {table_rows, row};
    endtask

    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, bit typed, roots_t want);
        roots_t p;
        roots_t keep;
        while (!calm && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        p = solve_roots(a, b, c);
        if (typed && p !== want) begin
            $error("table row disagrees with predictor: a=%0d b=%0d c=%0d", a, b, c);
            errors++;
        end
        keep = typed ? want : p;
        pending_roots = {pending_roots, keep};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // result side: random stalls, compare at the rising edge
    initial begin
        roots_t e;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= calm || ($urandom_range(99) >= 20);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_roots.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    e = pending_roots.pop_front();
                    if (m_root_status !== e.status) begin
                        $error("root_status exp %0d got %0d", e.status, m_root_status);
                        errors++;
                    end
                    if (m_root_plus !== e.plus) begin
                        $error("root_plus exp %0d got %0d", e.plus, m_root_plus);
                        errors++;
                    end
                    if (m_root_minus !== e.minus) begin
                        $error("root_minus exp %0d got %0d", e.minus, m_root_minus);
                        errors++;
                    end
                    if (m_saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, m_saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    initial begin
        idle_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count = 0;
            else idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int a, b, c, kind;
        errors = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_coef_a = '0;
        s_coef_b = '0;
        s_coef_c = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // a zero and negative discriminant give all-zero roots
        add_row(0, 0, 0, 1, '{qrs_pkg::ST_A_ZERO, 0, 0, 0});
        add_row(0, 32767, -32768, 1, '{qrs_pkg::ST_A_ZERO, 0, 0, 0});
        add_row(256, 0, 256, 1, '{qrs_pkg::ST_NEG_DISC, 0, 0, 0});
        add_row(-32768, 0, -32768, 1, '{qrs_pkg::ST_NEG_DISC, 0, 0, 0});
        // x^2 = 0: double root at zero
        add_row(256, 0, 0, 1, '{qrs_pkg::ST_DOUBLE, 0, 0, 0});
        // x^2 - 2x + 1: double root at one
        add_row(256, -512, 256, 1, '{qrs_pkg::ST_DOUBLE, 32'h10000, 32'h10000, 0});
        // x^2 - 1: roots at plus and minus one
        add_row(256, 0, -256, 1, '{qrs_pkg::ST_TWO_ROOTS, 32'h10000, -32'sh10000, 0});
        // tiny a, large b: plus root just past the positive bound
        add_row(1, -32768, -32768, 1,
                '{qrs_pkg::ST_TWO_ROOTS, 32'h7fffffff, -32'sh8000, 1});
        add_row(1, 32767, 0);
        add_row(-1, 32767, 0);
        add_row(1, -32768, 0);
        add_row(-32768, -32768, 32767);
        add_row(32767, 32767, -32768);
        add_row(-32768, 32767, 32767);
        add_row(32767, -32768, -32768);
        add_row(-1, -1, -1);
        add_row(3, 7, -5);
        add_row(-7, 100, 9);
        add_row(1, 2, 1);
        add_row(4, 4, 1);
        foreach (table_rows[i])
            send_coefs(table_rows[i].a, table_rows[i].b, table_rows[i].c,
                       table_rows[i].typed, table_rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 300 && n < 400);
            kind = $urandom_range(9);
            a = $signed(16'($urandom));
            b = $signed(16'($urandom));
            c = $signed(16'($urandom));
            if (kind == 0) a = 0;
            else if (kind == 1) begin
                // perfect square: a(x-r)^2 gives a double root
                a = $urandom_range(1, 16) * ($urandom_range(1) ? 1 : -1);
                b = -2 * a * $signed(5'($urandom));
                c = (b * b) / (4 * a);
            end else if (kind == 2) begin
                a = $signed(4'($urandom));
                c = $signed(6'($urandom));
            end else if (kind == 3) begin
                a = $signed(16'($urandom)) >>> $urandom_range(8, 15);
                b = $signed(16'($urandom)) >>> $urandom_range(0, 8);
            end
            send_coefs(CW'(a), CW'(b), CW'(c), 1'b0, '0);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
